### rtl/gbp_pkg.sv
`default_nettype none
package gbp_pkg;

  localparam int MAX_UNITS_DEF     = 16;
  localparam int GROUP_STORE_DEF   = 64;
  localparam int ORDER_ENTRIES     = 16;
  localparam int ENTRY_W           = 4;
  localparam int ORDER_W           = ORDER_ENTRIES * ENTRY_W;
  localparam int COUNT_W           = 5;
  localparam int BYTES_W           = 7;
  localparam int POS_W             = 7;
  localparam int PROD_W            = 12;
  localparam int DATA_W            = 8;
  localparam int CFG_AW            = 5;
  localparam int CFG_DW            = 64;
  localparam int REG_IDX_W         = 2;

  localparam logic [REG_IDX_W-1:0] REG_UNIT_ORDER = 2'd0;
  localparam logic [REG_IDX_W-1:0] REG_UNIT_COUNT = 2'd1;
  localparam logic [REG_IDX_W-1:0] REG_UNIT_BYTES = 2'd2;

  localparam logic [ORDER_W-1:0] UNIT_ORDER_RST = 64'd1;
  localparam logic [COUNT_W-1:0] UNIT_COUNT_RST = 5'd2;
  localparam logic [BYTES_W-1:0] UNIT_BYTES_RST = 7'd1;

  // Configuration as seen by the datapath.
  typedef struct packed {
    logic [ORDER_W-1:0] unit_order;
    logic [BYTES_W-1:0] unit_bytes;
    logic [POS_W-1:0]   group_size;
    logic               ok;
    logic               wr;
  } gbp_cfg_t;

  typedef struct packed {
    logic store;
    logic pass_load;
    logic rd_en;
  } gbp_cmd_t;

  typedef struct packed {
    logic cfg_ok;
    logic run_end;
    logic rd_last;
  } gbp_status_t;

endpackage
`default_nettype wire

### rtl/gbp_if.sv
`default_nettype none
interface gbp_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       end_of_stream;

  modport source (output valid, output data_byte, output end_of_stream, input ready);
  modport sink (input valid, input data_byte, input end_of_stream, output ready);
endinterface

interface gbp_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       last_of_run;
  logic       stream_done;
  logic       config_error;

  modport source (output valid, output out_byte, output last_of_run, output stream_done,
                  output config_error, input ready);
  modport sink (input valid, input out_byte, input last_of_run, input stream_done,
                input config_error, output ready);
endinterface
`default_nettype wire

### rtl/gbp_ram.sv
`default_nettype none
module gbp_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule
`default_nettype wire

### rtl/gbp_regs.sv
`default_nettype none
module gbp_regs import gbp_pkg::*; #(
  parameter int MAX_UNITS         = MAX_UNITS_DEF,
  parameter int GROUP_STORE_BYTES = GROUP_STORE_DEF
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              psel,
  input  wire logic              penable,
  input  wire logic              pwrite,
  input  wire logic [CFG_AW-1:0] paddr,
  input  wire logic [CFG_DW-1:0] pwdata,
  output logic      [CFG_DW-1:0] prdata,
  output logic                   pready,
  output gbp_cfg_t               cfg
);

  localparam int LIMIT = (MAX_UNITS < ORDER_ENTRIES) ? MAX_UNITS : ORDER_ENTRIES;

  logic [ORDER_W-1:0]   unit_order_r;
  logic [COUNT_W-1:0]   unit_count_r;
  logic [BYTES_W-1:0]   unit_bytes_r;
  logic [REG_IDX_W-1:0] reg_idx;
  logic                 wr_req;
  logic                 idx_known;
  logic [PROD_W-1:0]    product;
  logic [ORDER_ENTRIES-1:0] hit;
  logic [ORDER_ENTRIES-1:0] want;
  logic                 range_ok;
  logic [ENTRY_W-1:0]   entry;

  assign reg_idx   = paddr[CFG_AW-1:CFG_AW-REG_IDX_W];
  assign wr_req    = psel && penable && pwrite;
  assign idx_known = (reg_idx == REG_UNIT_ORDER) || (reg_idx == REG_UNIT_COUNT) ||
                     (reg_idx == REG_UNIT_BYTES);
  assign pready    = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      unit_order_r <= UNIT_ORDER_RST;
      unit_count_r <= UNIT_COUNT_RST;
      unit_bytes_r <= UNIT_BYTES_RST;
    end else if (wr_req) begin
      case (reg_idx)
        REG_UNIT_ORDER: unit_order_r <= pwdata[ORDER_W-1:0];
        REG_UNIT_COUNT: unit_count_r <= pwdata[COUNT_W-1:0];
        REG_UNIT_BYTES: unit_bytes_r <= pwdata[BYTES_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      REG_UNIT_ORDER: prdata = unit_order_r;
      REG_UNIT_COUNT: prdata = {{(CFG_DW-COUNT_W){1'b0}}, unit_count_r};
      REG_UNIT_BYTES: prdata = {{(CFG_DW-BYTES_W){1'b0}}, unit_bytes_r};
      default:        prdata = '0;
    endcase
  end

  // The order is a permutation when every used entry is in range and the used
  // entries between them hit every destination unit.
  always_comb begin
    hit      = '0;
    range_ok = 1'b1;
    entry    = '0;
    for (int k = 0; k < ORDER_ENTRIES; k++) begin
      entry = unit_order_r[k*ENTRY_W +: ENTRY_W];
      if (COUNT_W'(k) < unit_count_r) begin
        if ({1'b0, entry} >= unit_count_r) begin
          range_ok = 1'b0;
        end
        hit[entry] = 1'b1;
      end
    end
  end

  assign want    = ORDER_ENTRIES'(({1'b0, {ORDER_ENTRIES{1'b0}}} + 1'b1 << unit_count_r) -
                                  {{ORDER_ENTRIES{1'b0}}, 1'b1});
  assign product = PROD_W'(unit_count_r) * PROD_W'(unit_bytes_r);

  assign cfg.unit_order = unit_order_r;
  assign cfg.unit_bytes = unit_bytes_r;
  assign cfg.group_size = product[POS_W-1:0];
  assign cfg.wr         = wr_req && idx_known;
  assign cfg.ok         = (unit_count_r != '0) && (unit_count_r <= COUNT_W'(LIMIT)) &&
                          (unit_bytes_r != '0) && (product <= PROD_W'(GROUP_STORE_BYTES)) &&
                          range_ok && (hit == want);

endmodule
`default_nettype wire

### rtl/gbp_ctrl.sv
`default_nettype none
module gbp_ctrl import gbp_pkg::*; (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_ready,
  output logic             out_valid,
  input  wire logic        out_ready,
  input  wire gbp_status_t status,
  output gbp_cmd_t         cmd
);

  typedef enum logic {
    ST_IDLE,
    ST_DRAIN
  } state_t;

  state_t state_r;
  state_t state_nxt;
  logic   out_valid_r;
  logic   out_valid_nxt;
  logic   out_free;
  logic   accept;

  assign out_free  = !out_valid_r || out_ready;
  assign in_ready  = (state_r == ST_IDLE) && out_free;
  assign accept    = in_valid && in_ready;
  assign out_valid = out_valid_r;

  always_comb begin
    state_nxt     = state_r;
    out_valid_nxt = out_valid_r && !out_ready;
    cmd           = '0;
    case (state_r)
      ST_IDLE: begin
        if (accept) begin
          if (!status.cfg_ok) begin
            cmd.pass_load = 1'b1;
            out_valid_nxt = 1'b1;
          end else begin
            cmd.store = 1'b1;
            if (status.run_end) begin
              state_nxt = ST_DRAIN;
            end
          end
        end
      end
      ST_DRAIN: begin
        // The read register of the store is the output register, so a read is
        // only issued when the byte it holds has gone or is going.
        if (out_free) begin
          cmd.rd_en     = 1'b1;
          out_valid_nxt = 1'b1;
          if (status.rd_last) begin
            state_nxt = ST_IDLE;
          end
        end else begin
          out_valid_nxt = out_valid_r;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule
`default_nettype wire

### rtl/gbp_dpath.sv
`default_nettype none
module gbp_dpath import gbp_pkg::*; #(
  parameter int GROUP_STORE_BYTES = GROUP_STORE_DEF
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire gbp_cfg_t          cfg,
  input  wire gbp_cmd_t          cmd,
  output gbp_status_t            status,
  input  wire logic [DATA_W-1:0] in_byte,
  input  wire logic              in_eos,
  output logic      [DATA_W-1:0] out_byte,
  output logic                   out_last,
  output logic                   out_done,
  output logic                   out_err
);

  localparam int AW = $clog2(GROUP_STORE_BYTES);

  logic [POS_W-1:0]   pos_r;
  logic [BYTES_W-1:0] off_r;
  logic [ENTRY_W-1:0] unit_r;
  logic [POS_W-1:0]   rd_idx_r;
  logic [POS_W-1:0]   drain_len_r;
  logic               src_arr_r;
  logic               eos_r;
  logic               pass_sel_r;
  logic [DATA_W-1:0]  pass_byte_r;
  logic               last_r;
  logic               done_r;
  logic               err_r;

  logic [POS_W-1:0]   pos_inc;
  logic [BYTES_W-1:0] off_inc;
  logic               complete;
  logic [ENTRY_W-1:0] entry;
  logic [PROD_W-1:0]  dest_full;
  logic [DATA_W-1:0]  grp_q;
  logic [DATA_W-1:0]  arr_q;

  assign pos_inc   = pos_r + POS_W'(1);
  assign off_inc   = off_r + BYTES_W'(1);
  assign complete  = (pos_inc == cfg.group_size);
  assign entry     = cfg.unit_order[{unit_r, 2'b00} +: ENTRY_W];
  // A byte at offset r of source unit k goes to offset r of unit order[k].
  assign dest_full = PROD_W'(entry) * PROD_W'(cfg.unit_bytes) + PROD_W'(off_r);

  assign status.cfg_ok  = cfg.ok;
  assign status.run_end = complete || in_eos;
  assign status.rd_last = ((rd_idx_r + POS_W'(1)) == drain_len_r);

  gbp_ram #(.WIDTH(DATA_W), .DEPTH(GROUP_STORE_BYTES)) u_group_store (
    .clk   (clk),
    .we    (cmd.store),
    .waddr (dest_full[AW-1:0]),
    .wdata (in_byte),
    .re    (cmd.rd_en),
    .raddr (rd_idx_r[AW-1:0]),
    .rdata (grp_q)
  );

  gbp_ram #(.WIDTH(DATA_W), .DEPTH(GROUP_STORE_BYTES)) u_arrival_store (
    .clk   (clk),
    .we    (cmd.store),
    .waddr (pos_r[AW-1:0]),
    .wdata (in_byte),
    .re    (cmd.rd_en),
    .raddr (rd_idx_r[AW-1:0]),
    .rdata (arr_q)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r       <= '0;
      off_r       <= '0;
      unit_r      <= '0;
      rd_idx_r    <= '0;
      drain_len_r <= '0;
      src_arr_r   <= 1'b0;
      eos_r       <= 1'b0;
      pass_sel_r  <= 1'b0;
    end else begin
      if (cfg.wr || cmd.pass_load) begin
        pos_r  <= '0;
        off_r  <= '0;
        unit_r <= '0;
      end else if (cmd.store) begin
        if (status.run_end) begin
          pos_r       <= '0;
          off_r       <= '0;
          unit_r      <= '0;
          drain_len_r <= pos_inc;
          // A completed group drains permuted even when it closes the stream.
          src_arr_r   <= !complete;
          eos_r       <= in_eos;
        end else begin
          pos_r <= pos_inc;
          if (off_inc == cfg.unit_bytes) begin
            off_r  <= '0;
            unit_r <= unit_r + ENTRY_W'(1);
          end else begin
            off_r <= off_inc;
          end
        end
      end

      if (cmd.store && status.run_end) begin
        rd_idx_r <= '0;
      end else if (cmd.rd_en) begin
        rd_idx_r <= rd_idx_r + POS_W'(1);
      end

      if (cmd.pass_load) begin
        pass_sel_r <= 1'b1;
      end else if (cmd.rd_en) begin
        pass_sel_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.pass_load) begin
      pass_byte_r <= in_byte;
      last_r      <= 1'b1;
      done_r      <= in_eos;
      err_r       <= 1'b1;
    end else if (cmd.rd_en) begin
      last_r <= status.rd_last;
      done_r <= eos_r;
      err_r  <= 1'b0;
    end
  end

  assign out_byte = pass_sel_r ? pass_byte_r : (src_arr_r ? arr_q : grp_q);
  assign out_last = last_r;
  assign out_done = done_r;
  assign out_err  = err_r;

endmodule
`default_nettype wire

### rtl/grouped_byte_permuter_top.sv
`default_nettype none
// Grouped byte permuter.
// Bytes arrive on in_ch and are collected into groups of unit_count units of
// unit_bytes bytes. A byte of source unit k is stored in destination unit
// unit_order[k] at the same offset. When the last byte of a group is taken the
// whole permuted group is sent on out_ch, one byte per request, with
// last_of_run on its final byte. A byte carrying end_of_stream on a partial
// group releases the bytes held so far, in arrival order, with stream_done set.
// While the configuration is invalid every byte passes straight through with
// config_error set. The user must write the registers over the APB port only
// while idle; the block itself does not enforce it. Any write to a known
// register drops a partly filled group. After a closing byte of an N-byte run
// is taken the block enters its drain state and reads out all N bytes; the
// group store's registered read port is the output register, so the drain
// gives one byte per cycle and simply holds while the receiver stalls. No
// input is taken during a drain. A pass-through result is registered and
// appears in the cycle after its byte is taken. Reset empties the group and
// loads the default order, which swaps adjacent bytes.
module grouped_byte_permuter_top import gbp_pkg::*; #(
  parameter int MAX_UNITS         = MAX_UNITS_DEF,
  parameter int GROUP_STORE_BYTES = GROUP_STORE_DEF
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  gbp_in_if.sink                 in_ch,
  gbp_out_if.source              out_ch,
  input  wire logic              psel,
  input  wire logic              penable,
  input  wire logic              pwrite,
  input  wire logic [CFG_AW-1:0] paddr,
  input  wire logic [CFG_DW-1:0] pwdata,
  output logic      [CFG_DW-1:0] prdata,
  output logic                   pready
);

  gbp_cfg_t    cfg;
  gbp_cmd_t    cmd;
  gbp_status_t status;

  gbp_regs #(
    .MAX_UNITS         (MAX_UNITS),
    .GROUP_STORE_BYTES (GROUP_STORE_BYTES)
  ) u_regs (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  gbp_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .in_ready  (in_ch.ready),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .status    (status),
    .cmd       (cmd)
  );

  gbp_dpath #(
    .GROUP_STORE_BYTES (GROUP_STORE_BYTES)
  ) u_dpath (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg      (cfg),
    .cmd      (cmd),
    .status   (status),
    .in_byte  (in_ch.data_byte),
    .in_eos   (in_ch.end_of_stream),
    .out_byte (out_ch.out_byte),
    .out_last (out_ch.last_of_run),
    .out_done (out_ch.stream_done),
    .out_err  (out_ch.config_error)
  );

endmodule
`default_nettype wire

### bench/tb.sv
`timescale 1ns / 1ps
module tb;
  import gbp_pkg::*;

  localparam int STORE_BYTES = GROUP_STORE_DEF;
  localparam int UNIT_LIMIT  = (MAX_UNITS_DEF < ORDER_ENTRIES) ? MAX_UNITS_DEF : ORDER_ENTRIES;
  localparam logic [REG_IDX_W-1:0] REG_SPARE = 2'd3;
  localparam int IDLE_SETTLE     = 4;
  localparam int STALL_LIMIT     = 4000;
  localparam int HOLD_CYCLES     = 300;
  localparam int TARGET_REQUESTS = 350;

  typedef struct packed {
    logic [DATA_W-1:0] data;
    logic              last;
    logic              done;
    logic              err;
  } perm_byte_t;

  class permute_scoreboard;
    logic [ORDER_W-1:0] unit_order;
    logic [COUNT_W-1:0] unit_count;
    logic [BYTES_W-1:0] unit_bytes;
    int unsigned        held;
    logic [DATA_W-1:0]  permuted [STORE_BYTES];
    logic [DATA_W-1:0]  arrived [STORE_BYTES];
    perm_byte_t         expected_bytes [$];
    int                 mismatches;
    int                 checked;
    int                 passed_through;

    function new();
      unit_order     = UNIT_ORDER_RST;
      unit_count     = UNIT_COUNT_RST;
      unit_bytes     = UNIT_BYTES_RST;
      held           = 0;
      mismatches     = 0;
      checked        = 0;
      passed_through = 0;
    endfunction

    function void complain(string msg);
      if (mismatches < 10) $display("MISMATCH %s", msg);
      mismatches++;
    endfunction

    function void write_reg(logic [REG_IDX_W-1:0] idx, logic [CFG_DW-1:0] value);
      case (idx)
        REG_UNIT_ORDER: unit_order = value[ORDER_W-1:0];
        REG_UNIT_COUNT: unit_count = value[COUNT_W-1:0];
        REG_UNIT_BYTES: unit_bytes = value[BYTES_W-1:0];
        default: return;
      endcase
      // Any write to a known register drops a partly filled group.
      held = 0;
    endfunction

    function bit cfg_ok();
      logic [15:0] seen;
      int unsigned d;
      int          k;
      seen = '0;
      if (unit_count == 0 || unit_count > UNIT_LIMIT || unit_bytes == 0) return 0;
      if (int'(unit_count) * int'(unit_bytes) > STORE_BYTES) return 0;
      for (k = 0; k < int'(unit_count); k++) begin
        d = unit_order[4*k +: 4];
        if (d >= unit_count || seen[d]) return 0;
        seen[d] = 1'b1;
      end
      return 1;
    endfunction

    function void note_request(logic [DATA_W-1:0] b, logic eos);
      int unsigned gsize;
      int unsigned pos;
      int unsigned dest;
      int unsigned i;
      if (!cfg_ok()) begin
        held = 0;
        expected_bytes.push_back(perm_byte_t'{b, 1'b1, eos, 1'b1});
        return;
      end
      gsize = int'(unit_count) * int'(unit_bytes);
      pos = (held >= gsize) ? 0 : held;
      dest = int'(unit_order[4*(pos / unit_bytes) +: 4]) * int'(unit_bytes)
             + pos % unit_bytes;
      permuted[dest] = b;
      arrived[pos] = b;
      pos++;
      if (pos == gsize) begin
        for (i = 0; i < gsize; i++)
          expected_bytes.push_back(perm_byte_t'{permuted[i], i + 1 == gsize, eos, 1'b0});
        held = 0;
      end else if (eos) begin
        // A short group at end of stream goes out as it came in.
        for (i = 0; i < pos; i++)
          expected_bytes.push_back(perm_byte_t'{arrived[i], i + 1 == pos, 1'b1, 1'b0});
        held = 0;
      end else begin
        held = pos;
      end
    endfunction

    function void check_result(perm_byte_t got);
      perm_byte_t want;
      if (expected_bytes.size() == 0) begin
        complain($sformatf("unexpected byte %02h last %0b done %0b err %0b",
                           got.data, got.last, got.done, got.err));
        return;
      end
      want = expected_bytes.pop_front();
      checked++;
      if (got.err) passed_through++;
      if (got.data !== want.data || got.last !== want.last ||
          got.done !== want.done || got.err !== want.err)
        complain($sformatf("byte %0d: expected %02h last %0b done %0b err %0b, got %02h %0b %0b %0b",
                           checked, want.data, want.last, want.done, want.err,
                           got.data, got.last, got.done, got.err));
    endfunction
  endclass

  logic              clk;
  logic              rst_n;
  logic              psel;
  logic              penable;
  logic              pwrite;
  logic [CFG_AW-1:0] paddr;
  logic [CFG_DW-1:0] pwdata;
  wire  [CFG_DW-1:0] prdata;
  wire               pready;

  gbp_in_if  in_ch ();
  gbp_out_if out_ch ();

  grouped_byte_permuter_top u_dut (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_ch   (in_ch),
    .out_ch  (out_ch),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  permute_scoreboard sb;
  bit tx_eager;
  bit rx_eager;
  bit hold_off;
  bit pressure_go;
  int requests;
  int settings;
  int idle_cycles;

  initial clk = 1'b0;
  always #10 clk = ~clk;

  task automatic send_byte(input logic [DATA_W-1:0] b, input logic eos);
    int unsigned gap;
    gap = tx_eager ? 0 : $urandom_range(0, 8);
    @(negedge clk);
    if (gap != 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_ch.valid         <= 1'b1;
    in_ch.data_byte     <= b;
    in_ch.end_of_stream <= eos;
    do @(posedge clk); while (!in_ch.ready);
    sb.note_request(b, eos);
    requests++;
  endtask

  // Stop offering, then let every expected byte drain before going on.
  task automatic settle();
    @(negedge clk);
    in_ch.valid <= 1'b0;
    while (sb.expected_bytes.size() != 0) @(negedge clk);
    repeat (IDLE_SETTLE) @(negedge clk);
  endtask

  task automatic cfg_write(input logic [REG_IDX_W-1:0] idx, input logic [CFG_DW-1:0] value);
    logic [CFG_DW-1:0] mask;
    settle();
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= CFG_AW'({idx, 3'b000});
    pwdata  <= value;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    sb.write_reg(idx, value);
    // Read the register straight back.
    @(negedge clk);
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    case (idx)
      REG_UNIT_ORDER: mask = '1;
      REG_UNIT_COUNT: mask = CFG_DW'((1 << COUNT_W) - 1);
      REG_UNIT_BYTES: mask = CFG_DW'((1 << BYTES_W) - 1);
      default:        mask = '0;
    endcase
    if (((prdata ^ value) & mask) != 0)
      sb.complain($sformatf("register %0d reads %h, written %h", idx, prdata & mask,
                            value & mask));
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  task automatic apply_setting(input logic [ORDER_W-1:0] ord, input int cnt, input int nb);
    logic [CFG_DW-1:0] noise;
    noise = {$urandom, $urandom};
    cfg_write(REG_UNIT_ORDER, ord);
    cfg_write(REG_UNIT_COUNT, {noise[CFG_DW-1:COUNT_W], COUNT_W'(cnt)});
    cfg_write(REG_UNIT_BYTES, {noise[CFG_DW-1:BYTES_W], BYTES_W'(nb)});
    settings++;
  endtask

  function automatic logic [ORDER_W-1:0] random_order(input int cnt);
    logic [ORDER_W-1:0] v;
    logic [3:0]         t;
    int                 k;
    int                 j;
    v = {$urandom, $urandom};
    for (k = 0; k < cnt; k++) v[4*k +: 4] = 4'(k);
    for (k = cnt - 1; k > 0; k--) begin
      j = $urandom_range(0, k);
      t = v[4*k +: 4];
      v[4*k +: 4] = v[4*j +: 4];
      v[4*j +: 4] = t;
    end
    return v;
  endfunction

  // Result side: random back-pressure per byte, plus the long hold when asked.
  initial begin : result_sink
    int unsigned stall;
    stall = 0;
    forever begin
      @(negedge clk);
      if (hold_off || stall != 0) begin
        out_ch.ready <= 1'b0;
        if (stall != 0) stall--;
      end else begin
        out_ch.ready <= 1'b1;
      end
      @(posedge clk);
      if (rst_n && out_ch.valid && out_ch.ready) begin
        sb.check_result(perm_byte_t'{out_ch.out_byte, out_ch.last_of_run,
                                     out_ch.stream_done, out_ch.config_error});
        stall = rx_eager ? 0 : $urandom_range(0, 8);
      end
    end
  end

  initial begin : long_hold
    wait (pressure_go);
    repeat (30) @(posedge clk);
    hold_off = 1'b1;
    repeat (HOLD_CYCLES) @(posedge clk);
    hold_off = 1'b0;
  end

  always @(posedge clk) begin
    if (!rst_n || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) ||
        (psel && penable)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= STALL_LIMIT) begin
        $display("no progress for %0d cycles", idle_cycles);
        $display("tb: errors");
        $finish;
      end
    end
  end

  initial begin : stimulus
    int               phase;
    int               kind;
    int               cnt;
    int               nb;
    int               n;
    int               i;
    int               gsize;
    bit               bad;
    logic [ORDER_W-1:0] ord;
    sb                  = new();
    rst_n               = 1'b0;
    in_ch.valid         = 1'b0;
    in_ch.data_byte     = '0;
    in_ch.end_of_stream = 1'b0;
    out_ch.ready        = 1'b0;
    psel                = 1'b0;
    penable             = 1'b0;
    pwrite              = 1'b0;
    paddr               = '0;
    pwdata              = '0;
    tx_eager            = 1'b0;
    rx_eager            = 1'b0;
    hold_off            = 1'b0;
    pressure_go         = 1'b0;
    requests            = 0;
    settings            = 0;
    idle_cycles         = 0;
    repeat (5) @(negedge clk);
    rst_n <= 1'b1;

    // Reset order swaps adjacent bytes.
    send_byte(8'h00, 1'b0);
    send_byte(8'hFF, 1'b0);
    // End of stream on an empty group, then on a completing byte.
    send_byte(8'hA5, 1'b1);
    send_byte(8'h12, 1'b0);
    send_byte(8'h34, 1'b1);
    // A write past the last register leaves the held byte alone.
    send_byte(8'h77, 1'b0);
    cfg_write(REG_SPARE, {$urandom, $urandom});
    send_byte(8'h88, 1'b0);
    // Rewriting a register with its own value still drops the held byte.
    send_byte(8'h99, 1'b0);
    cfg_write(REG_UNIT_COUNT, 64'd2);
    send_byte(8'h11, 1'b0);
    send_byte(8'h22, 1'b0);
    // Full reversal of four single-byte units.
    apply_setting(64'h0123, 4, 1);
    send_byte(8'hDE, 1'b0);
    send_byte(8'hAD, 1'b0);
    send_byte(8'hBE, 1'b0);
    send_byte(8'hEF, 1'b0);
    // Zero units is invalid, so bytes pass straight through.
    apply_setting(64'h0123, 0, 1);
    send_byte(8'h3C, 1'b0);
    send_byte(8'hC3, 1'b1);

    phase = 0;
    while (requests < TARGET_REQUESTS) begin
      bad = 1'b0;
      kind = $urandom_range(0, 15);
      if (phase == 0) begin
        cnt = 16; nb = 4;
      end else if (phase == 1) begin
        cnt = 1; nb = 64;
      end else if (phase == 2) begin
        cnt = 16; nb = 1;
      end else begin
        cnt = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 16) : $urandom_range(1, 8);
        nb = $urandom_range(1, (64 / cnt < 4) ? 64 / cnt : 4);
      end
      ord = random_order(cnt);
      if (phase > 2) begin
        bad = (kind < 6);
        case (kind)
          0: cnt = 0;
          1: cnt = $urandom_range(17, 31);
          2: nb = 0;
          3: begin
            cnt = $urandom_range(2, 16);
            nb = $urandom_range(64 / cnt + 1, 64);
            ord = random_order(cnt);
          end
          4: begin
            // Two source units aimed at the same destination.
            cnt = $urandom_range(2, 16);
            nb = 1;
            ord = random_order(cnt);
            i = $urandom_range(1, cnt - 1);
            ord[4*i +: 4] = ord[3:0];
          end
          5: begin
            // A destination beyond the unit count.
            cnt = $urandom_range(1, 15);
            nb = 1;
            ord = random_order(cnt);
            i = $urandom_range(0, cnt - 1);
            ord[4*i +: 4] = 4'($urandom_range(cnt, 15));
          end
          default: ;
        endcase
      end
      apply_setting(ord, cnt, nb);
      // The first large group is sent without gaps so that it fills during the long hold.
      tx_eager = (phase == 0) || ($urandom_range(0, 3) == 0);
      rx_eager = (phase != 0) && ($urandom_range(0, 3) == 0);
      if (phase == 0) pressure_go = 1'b1;
      gsize = cnt * nb;
      if (bad) n = $urandom_range(8, 24);
      else n = $urandom_range(gsize, 2 * gsize + 4);
      if (n > TARGET_REQUESTS + 8 - requests) n = TARGET_REQUESTS + 8 - requests;
      for (i = 0; i < n; i++)
        send_byte(8'($urandom_range(0, 255)),
                  bad ? ($urandom_range(0, 3) == 0) : ($urandom_range(0, 2 * gsize) == 0));
      phase++;
    end

    settle();
    repeat (20) @(negedge clk);
    $display("summary: %0d bytes sent under %0d register settings, one long receiver hold",
             requests, settings);
    $display("summary: %0d result bytes checked, %0d of them passed through unpermuted",
             sb.checked, sb.passed_through);
    if (sb.expected_bytes.size() != 0)
      $display("%0d expected bytes never arrived", sb.expected_bytes.size());
    if (sb.mismatches == 0 && sb.expected_bytes.size() == 0) begin
      $display("tb: clean");
    end else begin
      $display("%0d mismatches", sb.mismatches);
      $display("tb: errors");
    end
    $finish;
  end

endmodule
